// ----- sv/bmct_pkg.sv -----
// Shared constants, codes, types and decode functions for the bracket matching command table.
package bmct_pkg;

    localparam int MAX_TOKENS_DEF  = 1024;
    localparam int MAX_NESTING_DEF = 256;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [3:0] TK_LEFT   = 4'd0;
    localparam logic [3:0] TK_RIGHT  = 4'd1;
    localparam logic [3:0] TK_INCR   = 4'd2;
    localparam logic [3:0] TK_DECR   = 4'd3;
    localparam logic [3:0] TK_INPUT  = 4'd4;
    localparam logic [3:0] TK_OUTPUT = 4'd5;
    localparam logic [3:0] TK_OPEN   = 4'd6;
    localparam logic [3:0] TK_CLOSE  = 4'd7;

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_MOVE   = 3'd1;
    localparam logic [2:0] CMD_ADD    = 3'd2;
    localparam logic [2:0] CMD_INPUT  = 3'd3;
    localparam logic [2:0] CMD_OUTPUT = 3'd4;
    localparam logic [2:0] CMD_BRANCH = 3'd5;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OPEN     = 2'd1;
    localparam logic [1:0] ERR_CLOSE    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_cmd_t;

    typedef struct packed {
        logic tok_we;
        logic open_we;
    } table_wr_t;

    function automatic logic [2:0] cmd_of(input logic [2:0] tok);
        logic [2:0] c;
        case ({1'b0, tok})
            TK_LEFT, TK_RIGHT:  c = CMD_MOVE;
            TK_INCR, TK_DECR:   c = CMD_ADD;
            TK_INPUT:           c = CMD_INPUT;
            TK_OUTPUT:          c = CMD_OUTPUT;
            default:            c = CMD_BRANCH;
        endcase
        return c;
    endfunction

    function automatic logic signed [1:0] amount_of(input logic [2:0] tok);
        logic signed [1:0] a;
        case ({1'b0, tok})
            TK_RIGHT, TK_INCR: a = 2'sd1;
            TK_LEFT, TK_DECR:  a = -2'sd1;
            default:           a = 2'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- sv/bmct_stack.sv -----
// Nesting stack of open bracket positions with a registered top and bottom entry.
module bmct_stack #(
    parameter int MAX_NESTING = bmct_pkg::MAX_NESTING_DEF,
    parameter int PW          = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bmct_pkg::stack_cmd_t                cmd,
    input  logic [PW-1:0]                       push_data,
    output logic [PW-1:0]                       top,
    output logic [PW-1:0]                       bottom,
    output logic [$clog2(MAX_NESTING+1)-1:0]    depth
);

    localparam int SW = $clog2(MAX_NESTING);
    localparam int DW = $clog2(MAX_NESTING + 1);

    logic [PW-1:0] stack_mem [MAX_NESTING];
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [DW-1:0] rd_ptr;
    logic [PW-1:0] top_reg;
    logic [PW-1:0] bottom_reg;

    always_comb
    begin
        if (cmd.clear)
        begin
            depth_next = '0;
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - DW'(1);
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    // the top after this edge sits one below the new depth
    assign rd_ptr = depth_next - DW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[depth_reg[SW-1:0]] <= push_data;
        end
        // bypass the entry being pushed
        top_reg <= cmd.push ? push_data : stack_mem[rd_ptr[SW-1:0]];
        if (cmd.push && depth_reg == '0)
        begin
            bottom_reg <= push_data;
        end
    end

    assign top    = top_reg;
    assign bottom = bottom_reg;
    assign depth  = depth_reg;

endmodule

// ----- sv/bmct_table.sv -----
// Token and partner memories: token with close partner per slot, open partner per slot.
module bmct_table #(
    parameter int PW = 10
) (
    input  logic                 clk,
    input  bmct_pkg::table_wr_t  wr,
    input  logic [PW-1:0]        tok_addr,
    input  logic [2:0]           tok_data,
    input  logic [PW-1:0]        close_part,
    input  logic [PW-1:0]        open_addr,
    input  logic [PW-1:0]        open_data,
    input  logic [PW-1:0]        rd_addr,
    output logic [2:0]           rd_tok,
    output logic [PW-1:0]        rd_close_part,
    output logic [PW-1:0]        rd_open_part
);

    localparam int DEPTH = 1 << PW;

    logic [PW+2:0] tok_mem  [DEPTH];
    logic [PW-1:0] open_mem [DEPTH];
    logic [PW+2:0] tok_rd_reg;
    logic [PW-1:0] open_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.tok_we)
        begin
            tok_mem[tok_addr] <= {tok_data, close_part};
        end
        tok_rd_reg <= tok_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.open_we)
        begin
            open_mem[open_addr] <= open_data;
        end
        open_rd_reg <= open_mem[rd_addr];
    end

    assign rd_tok        = tok_rd_reg[PW+2:PW];
    assign rd_close_part = tok_rd_reg[PW-1:0];
    assign rd_open_part  = open_rd_reg;

endmodule

// ----- sv/bracket_matching_command_table.sv -----
// Bracket matching command table: token program load, bracket pairing and command lookup.
// Each request is registered, and the result strobe and the result are registered from it.
// Throughput: one request every cycle; busy is never raised.
// The result is shown for one cycle only, as the receiver cannot stall.
// Reset clears count, nesting depth and error state; the memories keep no reset value.
module bracket_matching_command_table #(
    parameter int MAX_TOKENS  = bmct_pkg::MAX_TOKENS_DEF,
    parameter int MAX_NESTING = bmct_pkg::MAX_NESTING_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [3:0]         token,
    input  logic [9:0]         index,
    output logic               done,
    output logic               valid_res,
    output logic [2:0]         command,
    output logic signed [1:0]  amount,
    output logic signed [11:0] jump,
    output logic [1:0]         error_code,
    output logic [10:0]        error_position,
    output logic [10:0]        count
);

    localparam int PW = $clog2(MAX_TOKENS);
    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam int XW = (CW > 11) ? CW : 11;
    localparam int JW = PW + 2;

    logic accept;
    logic is_clear;
    logic is_append;
    logic is_open;
    logic is_close;
    logic table_full;
    logic stack_full;
    logic ovf_set;
    logic store;
    logic bad_close;
    logic [PW-1:0] pos;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          bad_seen_reg;
    logic [PW-1:0] bad_pos_reg;

    bmct_pkg::stack_cmd_t stack_cmd;
    bmct_pkg::table_wr_t  table_wr;
    logic [PW-1:0]        stack_top;
    logic [PW-1:0]        stack_bottom;
    logic [DW-1:0]        stack_depth;

    logic [2:0]    rd_tok;
    logic [PW-1:0] rd_close_part;
    logic [PW-1:0] rd_open_part;

    logic       req_reg;
    logic       rd_req_reg;
    logic [9:0] idx_reg;

    logic [CW-1:0]        err_pos;
    logic [1:0]           err_code;
    logic                 rd_ok;
    logic [PW-1:0]        idx_p;
    logic signed [JW-1:0] jump_w;

    logic               done_reg;
    logic               valid_reg;
    logic [2:0]         command_reg;
    logic signed [1:0]  amount_reg;
    logic signed [11:0] jump_reg;
    logic [1:0]         error_code_reg;
    logic [10:0]        error_position_reg;
    logic [10:0]        count_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // request decode and append checks
    assign is_clear   = accept && op == bmct_pkg::OP_CLEAR;
    assign is_append  = accept && op == bmct_pkg::OP_APPEND && !ovf_reg
                        && token <= bmct_pkg::TK_CLOSE;
    assign is_open    = token == bmct_pkg::TK_OPEN;
    assign is_close   = token == bmct_pkg::TK_CLOSE;
    assign table_full = count_reg == CW'(MAX_TOKENS);
    assign stack_full = stack_depth == DW'(MAX_NESTING);
    assign ovf_set    = is_append && (table_full || (is_open && stack_full));
    assign store      = is_append && !ovf_set;
    assign bad_close  = store && is_close && stack_depth == '0;
    assign pos        = count_reg[PW-1:0];

    assign stack_cmd.clear = is_clear;
    assign stack_cmd.push  = store && is_open;
    assign stack_cmd.pop   = store && is_close && stack_depth != '0;

    assign table_wr.tok_we  = store;
    assign table_wr.open_we = stack_cmd.pop;

    always_comb
    begin
        if (is_clear)
        begin
            count_next = '0;
        end
        else if (store)
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            bad_seen_reg <= 1'b0;
            bad_pos_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (is_clear)
            begin
                ovf_reg      <= 1'b0;
                bad_seen_reg <= 1'b0;
            end
            else
            begin
                if (ovf_set)
                begin
                    ovf_reg <= 1'b1;
                end
                // keep only the first unmatched close
                if (bad_close && !bad_seen_reg)
                begin
                    bad_seen_reg <= 1'b1;
                    bad_pos_reg  <= pos;
                end
            end
        end
    end

    bmct_stack #(
        .MAX_NESTING (MAX_NESTING),
        .PW          (PW)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stack_cmd),
        .push_data (pos),
        .top       (stack_top),
        .bottom    (stack_bottom),
        .depth     (stack_depth)
    );

    bmct_table #(
        .PW (PW)
    ) u_table (
        .clk           (clk),
        .wr            (table_wr),
        .tok_addr      (pos),
        .tok_data      (token[2:0]),
        .close_part    (stack_cmd.pop ? stack_top : '0),
        .open_addr     (stack_top),
        .open_data     (pos),
        .rd_addr       (PW'(index)),
        .rd_tok        (rd_tok),
        .rd_close_part (rd_close_part),
        .rd_open_part  (rd_open_part)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg    <= 1'b0;
            rd_req_reg <= 1'b0;
        end
        else
        begin
            req_reg    <= accept;
            rd_req_reg <= accept && op == bmct_pkg::OP_READ;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= index;
    end

    // status and lookup against the state left by this request
    always_comb
    begin
        if (bad_seen_reg)
        begin
            err_pos = CW'(bad_pos_reg);
        end
        else if (stack_depth != '0)
        begin
            err_pos = CW'(stack_bottom);
        end
        else
        begin
            err_pos = count_reg;
        end

        if (ovf_reg)
        begin
            err_code = bmct_pkg::ERR_OVERFLOW;
        end
        else if (bad_seen_reg)
        begin
            err_code = bmct_pkg::ERR_CLOSE;
        end
        else if (stack_depth != '0)
        begin
            err_code = bmct_pkg::ERR_OPEN;
        end
        else
        begin
            err_code = bmct_pkg::ERR_NONE;
        end
    end

    assign rd_ok = rd_req_reg && XW'(idx_reg) < XW'(err_pos)
                   && XW'(idx_reg) < XW'(count_reg);
    assign idx_p = PW'(idx_reg);

    always_comb
    begin
        if ({1'b0, rd_tok} == bmct_pkg::TK_OPEN)
        begin
            jump_w = $signed(JW'(rd_open_part)) + JW'(1) - $signed(JW'(idx_p));
        end
        else
        begin
            jump_w = $signed(JW'(rd_close_part)) - JW'(1) - $signed(JW'(idx_p));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_reg          <= rd_ok;
        command_reg        <= rd_ok ? bmct_pkg::cmd_of(rd_tok) : bmct_pkg::CMD_NONE;
        amount_reg         <= rd_ok ? bmct_pkg::amount_of(rd_tok) : 2'sd0;
        jump_reg           <= (rd_ok && bmct_pkg::cmd_of(rd_tok) == bmct_pkg::CMD_BRANCH)
                              ? 12'(jump_w) : 12'sd0;
        error_code_reg     <= err_code;
        error_position_reg <= 11'(err_pos);
        count_out_reg      <= 11'(count_reg);
    end

    assign done           = done_reg;
    assign valid_res      = valid_reg;
    assign command        = command_reg;
    assign amount         = amount_reg;
    assign jump           = jump_reg;
    assign error_code     = error_code_reg;
    assign error_position = error_position_reg;
    assign count          = count_out_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_reg |=> done)
        else $error("result strobe missing after a request");

    a_valid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> command != bmct_pkg::CMD_NONE)
        else $error("valid result without a command");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (command == bmct_pkg::CMD_NONE && amount == 2'sd0
                                  && jump == 12'sd0))
        else $error("invalid result carries a command");

    a_no_error_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_code == bmct_pkg::ERR_NONE) |-> error_position == count)
        else $error("error position differs from count with no error");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_depth <= DW'(MAX_NESTING))
        else $error("nesting depth beyond capacity");

endmodule
